// ===== hdl/assert_macros.svh =====
// Assertion macros used by the datapath of the decimal text converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that an expression never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    `ASSERT_CLK(lbl, clk, rst_n, !(expr), msg)

`endif

// ===== hdl/s2a_pkg.sv =====
// Types and constants of the signed integer to decimal text converter.
package s2a_pkg;

    localparam int unsigned VALUE_W       = 32;
    localparam int unsigned CHAR_W        = 6;
    localparam int unsigned DIGITS        = 10;
    localparam int unsigned DIGIT_W       = 4;
    localparam int unsigned BCD_W         = DIGITS * DIGIT_W;
    localparam int unsigned POS_W         = $clog2(DIGITS);
    localparam int unsigned BITS_PER_STEP = 4;
    localparam int unsigned STEPS         = VALUE_W / BITS_PER_STEP;
    localparam int unsigned STEP_W        = $clog2(STEPS);

    localparam logic [CHAR_W-1:0]  CHAR_ZERO  = CHAR_W'(48);
    localparam logic [CHAR_W-1:0]  CHAR_MINUS = CHAR_W'(45);
    localparam logic [DIGIT_W-1:0] DABBLE_MIN = DIGIT_W'(5);
    localparam logic [DIGIT_W-1:0] DABBLE_ADD = DIGIT_W'(3);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_LEAD,
        ST_SIGN,
        ST_DIGIT
    } t_state;

    typedef struct packed {
        logic load;
        logic conv;
        logic find_lead;
        logic emit_sign;
        logic emit_digit;
    } t_cmd;

    typedef struct packed {
        logic negative;
        logic pos_zero;
        logic out_free;
    } t_status;

endpackage

// ===== hdl/s2a_in_if.sv =====
// Input channel: one signed integer per transfer.
interface s2a_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [s2a_pkg::VALUE_W-1:0] signed_value;

    modport source (output valid, output signed_value, input ready);
    modport sink   (input valid, input signed_value, output ready);
endinterface

// ===== hdl/s2a_out_if.sv =====
// Output channel: one ASCII character per transfer.
interface s2a_out_if;
    logic                        valid;
    logic                        ready;
    logic [s2a_pkg::CHAR_W-1:0]  ascii_char;
    logic                        last_char;

    modport source (output valid, output ascii_char, output last_char, input ready);
    modport sink   (input valid, input ascii_char, input last_char, output ready);
endinterface

// ===== hdl/s2a_dpath.sv =====
// Datapath: magnitude, binary to BCD conversion, digit select and output register.
`include "assert_macros.svh"

module s2a_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  s2a_pkg::t_cmd                 i_cmd,
    output s2a_pkg::t_status              o_status,
    input  logic [s2a_pkg::VALUE_W-1:0]   i_value,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [s2a_pkg::CHAR_W-1:0]    o_out_char,
    output logic                          o_out_last
);
    import s2a_pkg::*;

    logic [VALUE_W-1:0] r_mag;
    logic [BCD_W-1:0]   r_bcd;
    logic               r_neg;
    logic [POS_W-1:0]   r_pos;
    logic               r_out_valid;
    logic [CHAR_W-1:0]  r_out_char;
    logic               r_out_last;

    logic [BCD_W-1:0]   n_bcd;
    logic [POS_W-1:0]   n_lead;
    logic [DIGIT_W-1:0] digit_sel;
    logic               out_free;

    // One shift-and-add-3 step: correct every digit, then shift in one bit.
    function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] bcd,
                                                 input logic bin);
        logic [BCD_W-1:0]   adj;
        logic [DIGIT_W-1:0] d;
        adj = bcd;
        for (int i = 0; i < DIGITS; i++) begin
            d = bcd[i*DIGIT_W +: DIGIT_W];
            if (d >= DABBLE_MIN) begin
                adj[i*DIGIT_W +: DIGIT_W] = DIGIT_W'(d + DABBLE_ADD);
            end
        end
        return {adj[BCD_W-2:0], bin};
    endfunction

    always_comb begin
        n_bcd = r_bcd;
        for (int b = 0; b < BITS_PER_STEP; b++) begin
            n_bcd = dabble(n_bcd, r_mag[VALUE_W-1-b]);
        end
    end

    // The highest nonzero digit sets where printing starts; zero starts at digit 0.
    always_comb begin
        n_lead = '0;
        for (int i = 0; i < DIGITS; i++) begin
            if (r_bcd[i*DIGIT_W +: DIGIT_W] != '0) begin
                n_lead = POS_W'(i);
            end
        end
    end

    assign digit_sel = r_bcd[r_pos*DIGIT_W +: DIGIT_W];
    assign out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg <= i_value[VALUE_W-1];
            r_mag <= i_value[VALUE_W-1] ? VALUE_W'(0 - i_value) : i_value;
            r_bcd <= '0;
        end else if (i_cmd.conv) begin
            r_mag <= {r_mag[VALUE_W-BITS_PER_STEP-1:0], BITS_PER_STEP'(0)};
            r_bcd <= n_bcd;
        end
        if (i_cmd.find_lead) begin
            r_pos <= n_lead;
        end else if (i_cmd.emit_digit && r_pos != '0) begin
            r_pos <= r_pos - POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_sign || i_cmd.emit_digit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_sign) begin
            r_out_char <= CHAR_MINUS;
            r_out_last <= 1'b0;
        end else if (i_cmd.emit_digit) begin
            r_out_char <= CHAR_W'(CHAR_ZERO + CHAR_W'(digit_sel));
            r_out_last <= (r_pos == '0);
        end
    end

    assign o_status.negative = r_neg;
    assign o_status.pos_zero = (r_pos == '0);
    assign o_status.out_free = out_free;
    assign o_out_valid       = r_out_valid;
    assign o_out_char        = r_out_char;
    assign o_out_last        = r_out_last;

    `ASSERT_CLK(a_emit_when_free, i_clk, i_rst_n, (i_cmd.emit_sign || i_cmd.emit_digit) |-> out_free, "character emitted while output register is occupied")
    `ASSERT_CLK(a_load_clears_bcd, i_clk, i_rst_n, i_cmd.load |=> (r_bcd == '0), "BCD register not cleared on load")
    `ASSERT_NEVER(a_last_is_digit, i_clk, i_rst_n, r_out_valid && r_out_last && (r_out_char == CHAR_MINUS), "minus sign flagged as last character")

endmodule

// ===== hdl/s2a_ctrl.sv =====
// Controller: sequences load, conversion steps, leading digit search and emission.
module s2a_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  s2a_pkg::t_status  i_status,
    output s2a_pkg::t_cmd     o_cmd
);
    import s2a_pkg::*;

    t_state            r_state;
    t_state            n_state;
    logic [STEP_W-1:0] r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CONV) begin
                r_step <= r_step + STEP_W'(1);
            end else begin
                r_step <= '0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                if (r_step == STEP_W'(STEPS - 1)) begin
                    n_state = ST_LEAD;
                end
            end
            ST_LEAD: begin
                n_state = i_status.negative ? ST_SIGN : ST_DIGIT;
            end
            ST_SIGN: begin
                if (i_status.out_free) begin
                    n_state = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (i_status.out_free && i_status.pos_zero) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_CONV:  o_cmd.conv       = 1'b1;
            ST_LEAD:  o_cmd.find_lead  = 1'b1;
            ST_SIGN:  o_cmd.emit_sign  = i_status.out_free;
            ST_DIGIT: o_cmd.emit_digit = i_status.out_free;
            default: begin
                o_cmd      = '0;
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== hdl/signed_int_to_decimal_ascii.sv =====
// After the input transfer come conversion steps of four bits each of
// shift-and-add-3 and the leading digit search; then one character per cycle
// while taken. An item gives 1 to 11 characters, and a new input is taken
// only once the last character of the previous one has been emitted.
// Synchronous active-low reset returns the controller to idle, output empty.
module signed_int_to_decimal_ascii (
    input  logic        i_clk,
    input  logic        i_rst_n,
    s2a_in_if.sink      i_in_ch,
    s2a_out_if.source   o_out_ch
);
    import s2a_pkg::*;

    t_cmd    cmd;
    t_status status;

    s2a_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_ch.valid),
        .o_in_ready (i_in_ch.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    s2a_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_value     (i_in_ch.signed_value),
        .i_out_ready (o_out_ch.ready),
        .o_out_valid (o_out_ch.valid),
        .o_out_char  (o_out_ch.ascii_char),
        .o_out_last  (o_out_ch.last_char)
    );

endmodule
